// ===== sv/sha512_pkg.sv =====
package sha512_pkg;

    localparam int COUNT_BITS = 64;

    localparam logic [63:0] INIT_512 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    localparam logic [63:0] INIT_384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    // Byte source selected for the buffer write.
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    typedef struct packed {
        logic       init_hash;
        logic       clear_fill;
        logic       buf_wr;
        logic [1:0] buf_src;
        logic       count_inc;
        logic       comp_start;
        logic       out_load;
        logic       out_step;
    } sha_cmd_t;

    typedef struct packed {
        logic [7:0] fill;
        logic       comp_busy;
        logic       out_done;
    } sha_stat_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int r);
        rotr = (x >> r) | (x << (64 - r));
    endfunction

endpackage

// ===== sv/sha512_stream_hasher.sv =====
// Each accepted byte is followed by a bookkeeping state before the next byte is taken.
// A full block then holds intake off for the 80 rounds on the single round unit, the
// final add and a release state. Closing a message adds padding at one byte per cycle
// while the block is not full, and one or two compressions, then eight or six digest
// transfers. Throughput is set by the shared round unit.
// Reset is synchronous, active low, and leaves the SHA-512 initial value and variant 0.
module sha512_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha512_pkg::*;

    sha_cmd_t  cmd;
    sha_stat_t stat;
    logic      variant_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) variant_reg <= 1'b0;
        else if (cfg_we) variant_reg <= cfg_wdata;
    end

    sha512_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_valid  (s_byte_valid),
        .s_message_end (s_message_end),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .stat          (stat),
        .cmd           (cmd)
    );

    sha512_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_variant   (variant_reg),
        .s_data_byte   (s_data_byte),
        .cmd           (cmd),
        .stat          (stat),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );
endmodule

// ===== sv/sha512_core.sv =====
module sha512_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic                                  init_hash,
    input  logic                                  init_sel,
    input  logic [15:0][63:0]                     block_in,
    output logic                                  busy,
    output logic [7:0][63:0]                      hash_out
);
    import sha512_pkg::*;

    logic [7:0][63:0]  h_reg;
    logic [7:0][63:0]  v_reg, v_next;
    logic [15:0][63:0] w_reg, w_next;
    logic [6:0]        round_reg;
    logic              busy_reg, fin_reg;
    logic [63:0]       wt, t1, t2, s0, s1, e, a, wnew;

    always_comb begin
        wt = w_reg[0];
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) +
             ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[round_reg] + wt;
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) +
             ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        w_next = {wnew, w_reg[15:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_512[i];
        end else if (init_hash) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= init_sel ? INIT_384[i] : INIT_512[i];
        end else if (start) begin
            busy_reg  <= 1'b1;
            round_reg <= '0;
            v_reg     <= h_reg;
            w_reg     <= block_in;
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            busy_reg <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
        end else if (busy_reg) begin
            v_reg     <= v_next;
            w_reg     <= w_next;
            round_reg <= round_reg + 7'd1;
            if (round_reg == 7'd79) fin_reg <= 1'b1;
        end
    end

    assign busy     = busy_reg;
    assign hash_out = h_reg;
endmodule

// ===== sv/sha512_ctrl.sv =====
module sha512_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_byte_valid,
    input  logic                  s_message_end,
    input  logic                  m_ready,
    output logic                  m_valid,
    input  sha512_pkg::sha_stat_t stat,
    output sha512_pkg::sha_cmd_t  cmd
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IN    = 3'd0;
    localparam logic [2:0] ST_COMP  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       open_reg, open_next;
    logic       closing_reg, closing_next;
    logic       tail_reg, tail_next;
    logic       acc;

    assign s_ready = (state_reg == ST_IN);
    assign m_valid = (state_reg == ST_OUT);
    assign acc     = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        open_next    = open_reg;
        closing_next = closing_reg;
        tail_next    = tail_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IN: begin
                if (acc) begin
                    if (!open_reg) begin
                        cmd.init_hash  = 1'b1;
                        cmd.clear_fill = 1'b1;
                        open_next      = 1'b1;
                    end
                    closing_next = s_message_end;
                    if (s_byte_valid) begin
                        cmd.buf_wr    = 1'b1;
                        cmd.buf_src   = SRC_DATA;
                        cmd.count_inc = 1'b1;
                        state_next    = ST_COMP;
                    end else if (s_message_end) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (stat.fill == 8'd128) begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_WAIT;
                end else begin
                    state_next = closing_reg ? ST_PAD : ST_IN;
                end
            end
            ST_WAIT: begin
                if (!stat.comp_busy) begin
                    cmd.clear_fill = 1'b1;
                    if (!closing_reg) begin
                        state_next = ST_IN;
                    end else if (open_reg) begin
                        state_next = ST_PAD;
                    end else if (!tail_reg) begin
                        tail_next  = 1'b1;
                        state_next = ST_FILL;
                    end else begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_PAD: begin
                cmd.buf_wr  = 1'b1;
                cmd.buf_src = SRC_PAD;
                open_next   = 1'b0;
                tail_next   = (stat.fill < 8'd112);
                state_next  = ST_FILL;
            end
            ST_FILL: begin
                if (stat.fill == 8'd128) begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_WAIT;
                end else begin
                    cmd.buf_wr  = 1'b1;
                    cmd.buf_src = (tail_reg && stat.fill >= 8'd112) ? SRC_LEN : SRC_ZERO;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.out_step = 1'b1;
                    if (stat.out_done) state_next = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IN;
            open_reg    <= 1'b0;
            closing_reg <= 1'b0;
            tail_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            closing_reg <= closing_next;
            tail_reg    <= tail_next;
        end
    end
endmodule

// ===== sv/sha512_dp.sv =====
module sha512_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_variant,
    input  logic [7:0]            s_data_byte,
    input  sha512_pkg::sha_cmd_t  cmd,
    output sha512_pkg::sha_stat_t stat,
    output logic [63:0]           m_digest_word,
    output logic [2:0]            m_word_index,
    output logic                  m_last_word
);
    import sha512_pkg::*;

    logic [15:0][7:0][7:0]    buf_reg;
    logic [7:0]               fill_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic                     var_reg;
    logic [2:0]               idx_reg;
    logic [7:0][63:0]         hash;
    logic                     busy;
    logic [127:0]             len_bits;
    logic [7:0]               wbyte;
    logic [3:0]               lpos;

    sha512_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.comp_start),
        .init_hash (cmd.init_hash),
        .init_sel  (cfg_variant),
        .block_in  (buf_reg),
        .busy      (busy),
        .hash_out  (hash)
    );

    assign len_bits = {{(128 - COUNT_BITS - 3){1'b0}}, count_reg, 3'b000};
    assign lpos     = fill_reg[3:0];

    always_comb begin
        case (cmd.buf_src)
            SRC_DATA: wbyte = s_data_byte;
            SRC_PAD:  wbyte = 8'h80;
            SRC_ZERO: wbyte = 8'h00;
            default:  wbyte = len_bits[(15 - lpos) * 8 +: 8];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.buf_wr) buf_reg[fill_reg[6:3]][~fill_reg[2:0]] <= wbyte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
            var_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (cmd.init_hash) var_reg <= cfg_variant;
            if (cmd.buf_wr) begin
                fill_reg <= (cmd.clear_fill ? 8'd0 : fill_reg) + 8'd1;
            end else if (cmd.clear_fill) begin
                fill_reg <= '0;
            end
            if (cmd.count_inc) begin
                count_reg <= (cmd.init_hash ? '0 : count_reg) + 1'b1;
            end else if (cmd.init_hash) begin
                count_reg <= '0;
            end
            if (cmd.out_load) idx_reg <= '0;
            else if (cmd.out_step) idx_reg <= idx_reg + 3'd1;
        end
    end

    assign stat.fill      = fill_reg;
    assign stat.comp_busy = busy || cmd.comp_start;
    assign stat.out_done  = m_last_word;
    assign m_digest_word  = hash[idx_reg];
    assign m_word_index   = idx_reg;
    assign m_last_word    = var_reg ? (idx_reg == 3'd5) : (idx_reg == 3'd7);
endmodule
